// ----- hw/rtl/soil_moisture_irrigation_ctrl_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the irrigation controller
// Shared concurrent assertion forms, reset-qualified on the active-low reset.
// ---------------------------------------------------------------------------
`ifndef SOIL_MOISTURE_IRRIGATION_CTRL_UNIT_ASSERT_SVH
`define SOIL_MOISTURE_IRRIGATION_CTRL_UNIT_ASSERT_SVH

// same-cycle implication
`define SMIC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMIC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/smic_pkg.sv -----
// ---------------------------------------------------------------------------
// smic_pkg
// Types, constants and helpers shared by the irrigation controller modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package smic_pkg;

	localparam int ADC_BITS       = 10;
	localparam int TIME_WIDTH_DEF = 32;
	localparam int CFG_W          = 32;
	localparam int CFG_IDX_W      = 3;
	localparam int QDEPTH         = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DRY_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DAILY_IVL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TWO_DAY_IVL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PUMP_BURST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd5;

	// register reset values
	localparam logic [7:0]       DRY_THRESHOLD_RST = 8'd40;
	localparam logic [CFG_W-1:0] DAILY_IVL_RST     = 32'd864000;
	localparam logic [CFG_W-1:0] TWO_DAY_IVL_RST   = 32'd1728000;
	localparam logic [15:0]      PUMP_BURST_RST    = 16'd50;
	localparam logic [15:0]      SETTLE_RST        = 16'd10;
	localparam logic [15:0]      DEBOUNCE_RST      = 16'd2;

	// watering levels
	localparam logic [1:0] LEVEL_ALWAYS  = 2'd1;
	localparam logic [1:0] LEVEL_DAILY   = 2'd2;
	localparam logic [1:0] LEVEL_TWO_DAY = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_BURST    = 2'd1,
		PH_SETTLE   = 2'd2,
		PH_DEBOUNCE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]       dry_threshold_pct;
		logic [CFG_W-1:0] daily_interval_ticks;
		logic [CFG_W-1:0] two_day_interval_ticks;
		logic [15:0]      pump_burst_ticks;
		logic [15:0]      settle_ticks;
		logic [15:0]      debounce_ticks;
	} cfg_t;

	// classified tick as held in the queue
	typedef struct packed {
		logic [7:0] moisture_pct;
		logic       options_level;
		logic       done_level;
	} tick_t;

	typedef struct packed {
		logic  valid;
		tick_t item;
	} q_head_t;

	// (full_scale - raw) * 100 / 708 == d * 25 / 177, done as a multiply by
	// ceil(2^22 / 177); exact since 25575 * 65 < 2^22.
	localparam logic [29:0] PCT_RECIP = 30'd23697;
	localparam int          PCT_SHIFT = 22;

	function automatic logic [7:0] moisture_to_pct(input logic [ADC_BITS-1:0] raw);
		logic [ADC_BITS-1:0] d;
		logic [14:0]         y;
		logic [29:0]         p;
		d = {ADC_BITS{1'b1}} - raw;
		y = 15'(d) * 15'd25;
		p = 30'(y) * PCT_RECIP;
		return p[PCT_SHIFT+7:PCT_SHIFT];
	endfunction

endpackage

// ----- hw/rtl/smic_if.sv -----
// ---------------------------------------------------------------------------
// smic channel interfaces
// Valid/ready channels for tick items and result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smic_tick_if import smic_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] moisture_raw;
	logic                options_level;
	logic                done_level;

	modport source (output valid, output moisture_raw, output options_level,
		output done_level, input ready);
	modport sink (input valid, input moisture_raw, input options_level,
		input done_level, output ready);
endinterface

interface smic_res_if ();
	logic       valid;
	logic       ready;
	logic [7:0] moisture_pct;
	logic       pump_on;
	logic       setup_mode;
	logic [1:0] watering_level;
	logic       burst_aborted;

	modport source (output valid, output moisture_pct, output pump_on,
		output setup_mode, output watering_level, output burst_aborted, input ready);
	modport sink (input valid, input moisture_pct, input pump_on,
		input setup_mode, input watering_level, input burst_aborted, output ready);
endinterface

// ----- hw/rtl/smic_front.sv -----
// ---------------------------------------------------------------------------
// smic_front
// Accepts tick items, maps the ADC sample to percent, queues them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "soil_moisture_irrigation_ctrl_unit_assert.svh"

module smic_front import smic_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	smic_tick_if.sink tick,
	output q_head_t head,
	input  logic    pop
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	tick_t            mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop_ok;
	tick_t            new_item;

	assign tick.ready = (count_q != CNT_W'(QDEPTH));
	assign push       = tick.valid && tick.ready;
	assign pop_ok     = pop && (count_q != '0);

	always_comb begin
		new_item.moisture_pct  = moisture_to_pct(tick.moisture_raw);
		new_item.options_level = tick.options_level;
		new_item.done_level    = tick.done_level;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop_ok) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop_ok) count_q <= count_q + 1'b1;
			else if (!push && pop_ok) count_q <= count_q - 1'b1;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	`SMIC_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QDEPTH), "queue overfilled")
	`SMIC_ASSERT_NXT(a_cnt_up, clk, arst_n, push && !pop_ok, count_q == $past(count_q) + 1'b1, "queue count missed a push")
	`SMIC_ASSERT_NXT(a_cnt_dn, clk, arst_n, pop_ok && !push, count_q == $past(count_q) - 1'b1, "queue count missed a pop")

endmodule

// ----- hw/rtl/smic_back.sv -----
// ---------------------------------------------------------------------------
// smic_back
// Runs the mode, level and pump phase logic once per queued tick item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "soil_moisture_irrigation_ctrl_unit_assert.svh"

module smic_back import smic_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  q_head_t head,
	output logic    pop,
	smic_res_if.source res
);

	localparam int CW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

	phase_t                phase_q, phase_d;
	logic [15:0]           cnt_q, cnt_d;
	logic                  prev_opt_q, prev_opt_d;
	logic                  prev_done_q, prev_done_d;
	logic                  setup_q, setup_d;
	logic [1:0]            level_q, level_d;
	logic [TIME_WIDTH-1:0] now_q;
	logic [TIME_WIDTH-1:0] last_q, last_d;

	logic                  pump_d;
	logic                  abort_d;
	logic                  res_valid_q;
	logic [7:0]            pct_q;
	logic                  pump_q;
	logic                  setup_out_q;
	logic [1:0]            level_out_q;
	logic                  abort_q;

	assign pop = head.valid && (!res_valid_q || res.ready);

	always_comb begin
		logic                  opt;
		logic                  dn;
		logic                  accepted;
		logic                  start;
		logic                  dry;
		logic [TIME_WIDTH-1:0] elapsed;
		logic [CFG_W-1:0]      iv;
		phase_t                eff;
		opt         = head.item.options_level;
		dn          = head.item.done_level;
		accepted    = 1'b0;
		start       = 1'b0;
		dry         = head.item.moisture_pct < cfg.dry_threshold_pct;
		elapsed     = now_q - last_q;
		iv          = (level_q == LEVEL_DAILY) ? cfg.daily_interval_ticks
			: cfg.two_day_interval_ticks;
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		prev_opt_d  = prev_opt_q;
		prev_done_d = prev_done_q;
		setup_d     = setup_q;
		level_d     = level_q;
		last_d      = last_q;
		pump_d      = 1'b0;
		abort_d     = 1'b0;
		eff         = phase_q;

		if ((phase_q == PH_SETTLE || phase_q == PH_DEBOUNCE) && cnt_q != '0) begin
			cnt_d = cnt_q - 1'b1;
		end else begin
			if (phase_q == PH_SETTLE || phase_q == PH_DEBOUNCE) eff = PH_IDLE;
			phase_d = eff;
			if (eff == PH_BURST) begin
				prev_opt_d  = opt;
				prev_done_d = dn;
				if (!opt || !dn) begin
					setup_d = 1'b1;
					phase_d = PH_IDLE;
					cnt_d   = '0;
					abort_d = 1'b1;
				end else if (cnt_q == '0) begin
					phase_d = PH_SETTLE;
					cnt_d   = cfg.settle_ticks;
				end else begin
					cnt_d  = cnt_q - 1'b1;
					pump_d = 1'b1;
				end
			end else begin
				if (!opt && prev_opt_q) begin
					setup_d  = !setup_q;
					accepted = 1'b1;
				end
				prev_opt_d = opt;
				if (setup_d) begin
					if (!dn && prev_done_q) begin
						level_d  = (level_q >= LEVEL_TWO_DAY) ? LEVEL_ALWAYS : level_q + 1'b1;
						accepted = 1'b1;
					end
					prev_done_d = dn;
				end else begin
					case (level_q)
						LEVEL_ALWAYS: start = dry;
						LEVEL_DAILY, LEVEL_TWO_DAY: begin
							if (dry && (CW'(elapsed) >= CW'(iv))) begin
								start  = 1'b1;
								last_d = now_q;
							end
						end
						default: start = 1'b0;
					endcase
				end
				if (start) begin
					phase_d = PH_BURST;
					cnt_d   = (cfg.pump_burst_ticks == '0) ? '0 : cfg.pump_burst_ticks - 1'b1;
					pump_d  = 1'b1;
				end else if (accepted) begin
					phase_d = PH_DEBOUNCE;
					cnt_d   = cfg.debounce_ticks;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			prev_opt_q  <= 1'b1;
			prev_done_q <= 1'b1;
			setup_q     <= 1'b0;
			level_q     <= LEVEL_ALWAYS;
			now_q       <= '0;
			last_q      <= '0;
		end else if (pop) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			prev_opt_q  <= prev_opt_d;
			prev_done_q <= prev_done_d;
			setup_q     <= setup_d;
			level_q     <= level_d;
			now_q       <= now_q + 1'b1;
			last_q      <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pct_q       <= head.item.moisture_pct;
			pump_q      <= pump_d;
			setup_out_q <= setup_d;
			level_out_q <= level_d;
			abort_q     <= abort_d;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.moisture_pct   = pct_q;
	assign res.pump_on        = pump_q;
	assign res.setup_mode     = setup_out_q;
	assign res.watering_level = level_out_q;
	assign res.burst_aborted  = abort_q;

	`SMIC_ASSERT_IMP(a_abort_no_pump, clk, arst_n, res_valid_q && abort_q, !pump_q && setup_out_q, "aborted burst left pump on or run mode")
	`SMIC_ASSERT_IMP(a_level_legal, clk, arst_n, res_valid_q, level_out_q != 2'd0, "watering level left 1..3")
	`SMIC_ASSERT_NXT(a_pump_setup, clk, arst_n, pop && pump_d, !setup_q, "pump running in setup mode")

endmodule

// ----- hw/rtl/soil_moisture_irrigation_ctrl_unit.sv -----
// ---------------------------------------------------------------------------
// soil_moisture_irrigation_ctrl_unit
// Soil moisture irrigation controller: one tick item in, one result item out.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake           payload
//  -------  ---  ------------------  ----------------------------------------
//  tick     in   valid/ready         moisture_raw, options_level, done_level
//  res      out  valid/ready         moisture_pct, pump_on, setup_mode,
//                                    watering_level, burst_aborted
//  cfg      in   cfg_we (no stall)   cfg_index, cfg_data
//
//  One tick item per cycle sustained while res.ready stays high; an accepted
//  item is written into a queue entry, then the back update loads the result register.
//  The back update (32-bit interval subtract and compare) sets the cycle.
//  A four-entry queue parts front and back; the front stalls only when it is
//  full, the back only when the result register is held by res.ready low.
//  Reset is asynchronous, active low; no clearing pass, ready right away.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module soil_moisture_irrigation_ctrl_unit import smic_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	smic_tick_if.sink            tick,
	smic_res_if.source           res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t    cfg_q;
	q_head_t head;
	logic    pop;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry_threshold_pct      <= DRY_THRESHOLD_RST;
			cfg_q.daily_interval_ticks   <= DAILY_IVL_RST;
			cfg_q.two_day_interval_ticks <= TWO_DAY_IVL_RST;
			cfg_q.pump_burst_ticks       <= PUMP_BURST_RST;
			cfg_q.settle_ticks           <= SETTLE_RST;
			cfg_q.debounce_ticks         <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DRY_THRESHOLD: cfg_q.dry_threshold_pct      <= cfg_data[7:0];
				CFG_DAILY_IVL:     cfg_q.daily_interval_ticks   <= cfg_data;
				CFG_TWO_DAY_IVL:   cfg_q.two_day_interval_ticks <= cfg_data;
				CFG_PUMP_BURST:    cfg_q.pump_burst_ticks       <= cfg_data[15:0];
				CFG_SETTLE:        cfg_q.settle_ticks           <= cfg_data[15:0];
				CFG_DEBOUNCE:      cfg_q.debounce_ticks         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// front: percent mapping and the item queue
	smic_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.head   (head),
		.pop    (pop)
	);

	// back: mode/level/pump phase update and the result register
	smic_back #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for soil_moisture_irrigation_ctrl_unit. Ticks go in
// through the tick channel, and each result is checked against an in-bench
// model of the controller or a hand-typed result. First a short directed plan,
// then five random register phases. The phases run from moderate values to
// the register extremes, with random idling and one long result stall.
// ---------------------------------------------------------------------------

module testbench;
	import smic_pkg::*;

	localparam int   WATCHDOG_LIMIT = 1000; // idle cycles before giving up
	localparam int   LONG_HOLD      = 80;   // result stall that backs up the queue
	localparam int   HOLD_AFTER     = 150;  // results seen before that stall
	localparam logic PRESSED        = 1'b0; // buttons are active low
	localparam logic RELEASED       = 1'b1;

	// one result item, field for field as on the res channel
	typedef struct packed {
		logic [7:0] moisture_pct;
		logic       pump_on;
		logic       setup_mode;
		logic [1:0] watering_level;
		logic       burst_aborted;
	} result_t;

	typedef enum logic { ROW_TICK, ROW_CFG } row_kind_t;

	// directed plan row: a tick (optionally with a hand-typed result) or a register write
	typedef struct packed {
		row_kind_t            kind;
		logic [ADC_BITS-1:0]  raw;
		logic                 opt;
		logic                 dn;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		logic                 typed;
		result_t              want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	smic_tick_if tick_ch ();
	smic_res_if  res_ch ();

	soil_moisture_irrigation_ctrl_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// -----------------------------------------------------------------------
	// Controller model: registers and state, advanced once per accepted tick
	// -----------------------------------------------------------------------
	cfg_t        cfg_model;
	logic        last_opt;     // options pin as last sampled
	logic        last_done;    // done pin as last sampled
	logic        setup_q;
	logic [1:0]  level_q;
	logic [31:0] tick_clock;   // tick count, wraps at TIME_WIDTH (32 here)
	logic [31:0] last_start;   // start time of the last timed burst
	phase_t      pump_phase;
	logic [15:0] phase_left;

	result_t     expected_readings[$];  // results owed by the block, oldest first
	plan_row_t   directed_plan[$];

	// tag travels with the tick payload, so the scoreboard knows which row it is
	logic        row_typed;
	result_t     row_exp;

	logic        calm;         // final stretch: no idling on either side
	int          fail_count;
	int          ticks_taken;
	int          results_seen;
	int          quiet_cycles;
	int          pump_ticks;
	int          timed_pump_ticks;
	int          abort_count;
	int          setup_ticks;

	task automatic advance_irrigation(input logic [ADC_BITS-1:0] raw, input logic opt,
			input logic dn, output result_t r);
		logic [31:0] now;
		logic [31:0] interval;
		logic        dry;
		logic        start;
		logic        accepted;
		r = '0;
		r.moisture_pct = 8'(((1023 - int'(raw)) * 100) / 708);
		now = tick_clock;
		tick_clock = tick_clock + 32'd1;
		start = 1'b0;
		accepted = 1'b0;
		if ((pump_phase == PH_SETTLE || pump_phase == PH_DEBOUNCE) && phase_left != 16'd0) begin
			// hold-off: tick is swallowed, pins not sampled
			phase_left = phase_left - 16'd1;
		end else if (pump_phase == PH_BURST) begin
			// pins tracked all through a burst, so a held press is no new edge later
			last_opt = opt;
			last_done = dn;
			if (opt == PRESSED || dn == PRESSED) begin
				setup_q = 1'b1;
				pump_phase = PH_IDLE;
				phase_left = 16'd0;
				r.burst_aborted = 1'b1;
			end else if (phase_left == 16'd0) begin
				pump_phase = PH_SETTLE;
				phase_left = cfg_model.settle_ticks;
			end else begin
				phase_left = phase_left - 16'd1;
				r.pump_on = 1'b1;
			end
		end else begin
			// idle, or a hold-off that just ran out: tick handled in full
			pump_phase = PH_IDLE;
			if (opt == PRESSED && last_opt == RELEASED) begin
				setup_q = ~setup_q;
				accepted = 1'b1;
			end
			last_opt = opt;
			if (setup_q) begin
				if (dn == PRESSED && last_done == RELEASED) begin
					level_q = (level_q == LEVEL_TWO_DAY) ? LEVEL_ALWAYS : level_q + 2'd1;
					accepted = 1'b1;
				end
				last_done = dn;
			end else begin
				dry = r.moisture_pct < cfg_model.dry_threshold_pct;
				interval = (level_q == LEVEL_DAILY) ? cfg_model.daily_interval_ticks
					: cfg_model.two_day_interval_ticks;
				if (level_q == LEVEL_ALWAYS) begin
					start = dry;
				end else if (level_q == LEVEL_DAILY || level_q == LEVEL_TWO_DAY) begin
					// elapsed time is modular; only timed levels stamp the start
					if (dry && now - last_start >= interval) begin
						start = 1'b1;
						last_start = now;
					end
				end
			end
			if (start) begin
				pump_phase = PH_BURST;
				phase_left = (cfg_model.pump_burst_ticks == 16'd0) ? 16'd0
					: cfg_model.pump_burst_ticks - 16'd1;
				r.pump_on = 1'b1;
			end else if (accepted) begin
				pump_phase = PH_DEBOUNCE;
				phase_left = cfg_model.debounce_ticks;
			end
		end
		r.setup_mode = setup_q;
		r.watering_level = level_q;
	endtask

	// -----------------------------------------------------------------------
	// Directed plan rows
	// -----------------------------------------------------------------------
	function automatic plan_row_t tick_row(input logic [ADC_BITS-1:0] raw, input logic opt,
			input logic dn);
		plan_row_t r;
		r = '0;
		r.kind = ROW_TICK;
		r.raw = raw;
		r.opt = opt;
		r.dn = dn;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input logic [ADC_BITS-1:0] raw, input logic opt,
			input logic dn, input logic [7:0] pct, input logic pump, input logic setup,
			input logic [1:0] lvl, input logic aborted);
		plan_row_t r;
		r = tick_row(raw, opt, dn);
		r.typed = 1'b1;
		r.want.moisture_pct = pct;
		r.want.pump_on = pump;
		r.want.setup_mode = setup;
		r.want.watering_level = lvl;
		r.want.burst_aborted = aborted;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		plan_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Drivers
	// -----------------------------------------------------------------------
	// offer one tick, now and then after a random gap unless calm; returns at the accepting edge
	task automatic offer_tick(input logic [ADC_BITS-1:0] raw, input logic opt, input logic dn,
			input logic typed, input result_t want);
		if (!calm && $urandom_range(0, 5) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.moisture_raw <= raw;
		tick_ch.options_level <= opt;
		tick_ch.done_level <= dn;
		row_typed <= typed;
		row_exp <= want;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
	endtask

	// stop offering and let every owed result come out, then leave slack;
	// a wait first so a tick taken at the last edge is already on the owed list
	task automatic quiesce();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// block applies the write at the next edge; model takes it now, nothing is in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_DRY_THRESHOLD: cfg_model.dry_threshold_pct = val[7:0];
			CFG_DAILY_IVL:     cfg_model.daily_interval_ticks = val;
			CFG_TWO_DAY_IVL:   cfg_model.two_day_interval_ticks = val;
			CFG_PUMP_BURST:    cfg_model.pump_burst_ticks = val[15:0];
			CFG_SETTLE:        cfg_model.settle_ticks = val[15:0];
			CFG_DEBOUNCE:      cfg_model.debounce_ticks = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Clock
	// -----------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Scoreboard: predict on tick acceptance, check on result acceptance.
	// Both handshakes sampled at the same edge in one process, predict first.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		result_t predicted;
		result_t want;
		result_t got;
		logic    moved;
		moved = 1'b0;
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready) begin
				advance_irrigation(tick_ch.moisture_raw, tick_ch.options_level,
					tick_ch.done_level, predicted);
				// hand-typed rows override the prediction; the model still steps
				expected_readings.push_back(row_typed ? row_exp : predicted);
				ticks_taken++;
				moved = 1'b1;
			end
			if (res_ch.valid && res_ch.ready) begin
				got.moisture_pct = res_ch.moisture_pct;
				got.pump_on = res_ch.pump_on;
				got.setup_mode = res_ch.setup_mode;
				got.watering_level = res_ch.watering_level;
				got.burst_aborted = res_ch.burst_aborted;
				results_seen++;
				moved = 1'b1;
				pump_ticks += got.pump_on;
				timed_pump_ticks += (got.pump_on && got.watering_level != LEVEL_ALWAYS);
				abort_count += got.burst_aborted;
				setup_ticks += got.setup_mode;
				if (expected_readings.size() == 0) begin
					$error("result with nothing expected: pct %0d pump %0d", got.moisture_pct,
						got.pump_on);
					fail_count++;
				end else begin
					want = expected_readings.pop_front();
					if (got.moisture_pct !== want.moisture_pct) begin
						$error("moisture_pct: expected %0d, got %0d", want.moisture_pct,
							got.moisture_pct);
						fail_count++;
					end
					if (got.pump_on !== want.pump_on) begin
						$error("pump_on: expected %0d, got %0d", want.pump_on, got.pump_on);
						fail_count++;
					end
					if (got.setup_mode !== want.setup_mode) begin
						$error("setup_mode: expected %0d, got %0d", want.setup_mode,
							got.setup_mode);
						fail_count++;
					end
					if (got.watering_level !== want.watering_level) begin
						$error("watering_level: expected %0d, got %0d", want.watering_level,
							got.watering_level);
						fail_count++;
					end
					if (got.burst_aborted !== want.burst_aborted) begin
						$error("burst_aborted: expected %0d, got %0d", want.burst_aborted,
							got.burst_aborted);
						fail_count++;
					end
				end
			end
		end
		// watchdog: nothing moving on either channel for too long
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Result side: random stall bursts, plus one long stall so the block's
	// queue fills and tick.ready drops while ticks keep being offered.
	// -----------------------------------------------------------------------
	initial begin : result_drain
		logic held_long;
		held_long = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && !held_long && results_seen >= HOLD_AFTER) begin
				held_long = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus
	// -----------------------------------------------------------------------
	initial begin : stimulus
		plan_row_t           row;
		logic [ADC_BITS-1:0] raw;
		logic                opt;
		logic                dn;
		int                  opt_hold;
		int                  dn_hold;
		int                  boundary;
		int                  n_items;

		// every input known from time zero
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.moisture_raw <= '0;
		tick_ch.options_level <= RELEASED;
		tick_ch.done_level <= RELEASED;
		row_typed <= 1'b0;
		row_exp <= '0;
		calm = 1'b0;
		fail_count = 0;
		ticks_taken = 0;
		results_seen = 0;
		quiet_cycles = 0;
		pump_ticks = 0;
		timed_pump_ticks = 0;
		abort_count = 0;
		setup_ticks = 0;
		opt_hold = 0;
		dn_hold = 0;

		// model at reset
		cfg_model.dry_threshold_pct = DRY_THRESHOLD_RST;
		cfg_model.daily_interval_ticks = DAILY_IVL_RST;
		cfg_model.two_day_interval_ticks = TWO_DAY_IVL_RST;
		cfg_model.pump_burst_ticks = PUMP_BURST_RST;
		cfg_model.settle_ticks = SETTLE_RST;
		cfg_model.debounce_ticks = DEBOUNCE_RST;
		last_opt = RELEASED;
		last_done = RELEASED;
		setup_q = 1'b0;
		level_q = LEVEL_ALWAYS;
		tick_clock = '0;
		last_start = '0;
		pump_phase = PH_IDLE;
		phase_left = '0;

		// Directed plan, reset registers (threshold 40, burst 50, settle 10, debounce 2).
		// Wettest sample, then driest: level 1 pumps at once when dry.
		directed_plan.push_back(typed_row(10'd0, RELEASED, RELEASED,
			8'd144, 1'b0, 1'b0, LEVEL_ALWAYS, 1'b0));
		directed_plan.push_back(typed_row(10'd1023, RELEASED, RELEASED,
			8'd0, 1'b1, 1'b0, LEVEL_ALWAYS, 1'b0));
		directed_plan.push_back(tick_row(10'd512, RELEASED, RELEASED));
		// options press mid-burst: pump off, abort flag, forced into setup
		directed_plan.push_back(typed_row(10'd1023, PRESSED, RELEASED,
			8'd0, 1'b0, 1'b1, LEVEL_ALWAYS, 1'b1));
		// options still held: no new edge
		directed_plan.push_back(tick_row(10'd1023, PRESSED, RELEASED));
		// done presses in setup walk the level 1 -> 2 -> 3 -> 1, each debounced
		directed_plan.push_back(typed_row(10'd1023, RELEASED, PRESSED,
			8'd0, 1'b0, 1'b1, LEVEL_DAILY, 1'b0));
		directed_plan.push_back(tick_row(10'd1023, PRESSED, PRESSED));
		directed_plan.push_back(tick_row(10'd1023, PRESSED, PRESSED));
		directed_plan.push_back(tick_row(10'd1023, RELEASED, RELEASED));
		directed_plan.push_back(typed_row(10'd1023, RELEASED, PRESSED,
			8'd0, 1'b0, 1'b1, LEVEL_TWO_DAY, 1'b0));
		directed_plan.push_back(tick_row(10'd1023, RELEASED, RELEASED));
		directed_plan.push_back(tick_row(10'd1023, RELEASED, RELEASED));
		directed_plan.push_back(tick_row(10'd1023, RELEASED, RELEASED));
		directed_plan.push_back(typed_row(10'd1023, RELEASED, PRESSED,
			8'd0, 1'b0, 1'b1, LEVEL_ALWAYS, 1'b0));
		directed_plan.push_back(tick_row(10'd1023, RELEASED, RELEASED));
		directed_plan.push_back(tick_row(10'd1023, RELEASED, RELEASED));
		// leaving setup while dry starts a burst in the same tick
		directed_plan.push_back(typed_row(10'd1023, PRESSED, RELEASED,
			8'd0, 1'b1, 1'b0, LEVEL_ALWAYS, 1'b0));
		// done press aborts too
		directed_plan.push_back(typed_row(10'd1023, RELEASED, PRESSED,
			8'd0, 1'b0, 1'b1, LEVEL_ALWAYS, 1'b1));
		// extremes: always dry, shortest burst, no settle, no debounce
		directed_plan.push_back(cfg_row(CFG_DRY_THRESHOLD, 32'd255));
		directed_plan.push_back(cfg_row(CFG_DAILY_IVL, 32'd0));
		directed_plan.push_back(cfg_row(CFG_TWO_DAY_IVL, 32'hFFFF_FFFF));
		directed_plan.push_back(cfg_row(CFG_PUMP_BURST, 32'd1));
		directed_plan.push_back(cfg_row(CFG_SETTLE, 32'd0));
		directed_plan.push_back(cfg_row(CFG_DEBOUNCE, 32'd0));
		directed_plan.push_back(tick_row(10'd0, RELEASED, RELEASED));
		directed_plan.push_back(typed_row(10'd0, PRESSED, RELEASED,
			8'd144, 1'b1, 1'b0, LEVEL_ALWAYS, 1'b0));
		// one-tick burst runs out with pump low, zero settle goes straight back
		directed_plan.push_back(typed_row(10'd0, RELEASED, RELEASED,
			8'd144, 1'b0, 1'b0, LEVEL_ALWAYS, 1'b0));
		directed_plan.push_back(tick_row(10'd0, RELEASED, RELEASED));
		directed_plan.push_back(tick_row(10'd0, PRESSED, RELEASED));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			if (row.kind == ROW_CFG) begin
				quiesce();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				offer_tick(row.raw, row.opt, row.dn, row.typed, row.want);
			end
		end

		// Random phases. Phase 2 carries the register maxima for burst and the
		// daily interval; the last one has maximal hold-offs and runs without idling.
		for (int p = 0; p < 5; p++) begin
			calm = (p == 4);
			quiesce();
			case (p)
				0: begin
					write_reg(CFG_DRY_THRESHOLD, 32'd40);
					write_reg(CFG_DAILY_IVL, 32'd30);
					write_reg(CFG_TWO_DAY_IVL, 32'd70);
					write_reg(CFG_PUMP_BURST, 32'd6);
					write_reg(CFG_SETTLE, 32'd4);
					write_reg(CFG_DEBOUNCE, 32'd3);
				end
				1: begin
					write_reg(CFG_DRY_THRESHOLD, $urandom_range(10, 130));
					write_reg(CFG_DAILY_IVL, $urandom_range(0, 40));
					write_reg(CFG_TWO_DAY_IVL, $urandom_range(0, 100));
					write_reg(CFG_PUMP_BURST, $urandom_range(1, 10));
					write_reg(CFG_SETTLE, $urandom_range(0, 6));
					write_reg(CFG_DEBOUNCE, $urandom_range(0, 4));
				end
				2: begin
					// long bursts end by presses; daily level never comes due
					write_reg(CFG_DRY_THRESHOLD, 32'd100);
					write_reg(CFG_DAILY_IVL, 32'hFFFF_FFFF);
					write_reg(CFG_TWO_DAY_IVL, 32'd0);
					write_reg(CFG_PUMP_BURST, 32'd65535);
					write_reg(CFG_SETTLE, 32'd0);
					write_reg(CFG_DEBOUNCE, 32'd1);
				end
				3: begin
					// nothing is ever dry
					write_reg(CFG_DRY_THRESHOLD, 32'd0);
					write_reg(CFG_DAILY_IVL, 32'd0);
					write_reg(CFG_TWO_DAY_IVL, $urandom());
					write_reg(CFG_PUMP_BURST, 32'd2);
					write_reg(CFG_SETTLE, 32'd2);
					write_reg(CFG_DEBOUNCE, 32'd0);
				end
				default: begin
					write_reg(CFG_DRY_THRESHOLD, 32'd255);
					write_reg(CFG_DAILY_IVL, 32'd5);
					write_reg(CFG_TWO_DAY_IVL, 32'd9);
					write_reg(CFG_PUMP_BURST, 32'd3);
					write_reg(CFG_SETTLE, 32'd65535);
					write_reg(CFG_DEBOUNCE, 32'd65535);
				end
			endcase
			n_items = calm ? 40 : 110;
			for (int i = 0; i < n_items; i++) begin
				// moisture: any value, the rails, or close to the dry threshold
				case ($urandom_range(0, 3))
					0: raw = 10'($urandom_range(0, 1023));
					1: raw = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
					default: begin
						boundary = 1023 - int'(cfg_model.dry_threshold_pct) * 708 / 100
							+ int'($urandom_range(0, 30)) - 15;
						raw = 10'((boundary < 0) ? 0 : (boundary > 1023) ? 1023 : boundary);
					end
				endcase
				// buttons mostly released; a press holds low for 1 to 3 ticks
				if (opt_hold > 0) begin
					opt = PRESSED;
					opt_hold--;
				end else if ($urandom_range(0, 11) == 0) begin
					opt = PRESSED;
					opt_hold = $urandom_range(0, 2);
				end else begin
					opt = RELEASED;
				end
				if (dn_hold > 0) begin
					dn = PRESSED;
					dn_hold--;
				end else if ($urandom_range(0, 9) == 0) begin
					dn = PRESSED;
					dn_hold = $urandom_range(0, 2);
				end else begin
					dn = RELEASED;
				end
				// occasional pin noise
				if ($urandom_range(0, 39) == 0) begin
					opt = 1'($urandom_range(0, 1));
					dn = 1'($urandom_range(0, 1));
				end
				offer_tick(raw, opt, dn, 1'b0, '0);
			end
		end

		quiesce();
		repeat (6) @(posedge clk);
		$display("covered %0d ticks and %0d results: %0d pumping (%0d on a timed level)",
			ticks_taken, results_seen, pump_ticks, timed_pump_ticks);
		$display("  %0d aborted bursts, %0d ticks in setup mode, %0d mismatches",
			abort_count, setup_ticks, fail_count);
		if (fail_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/smic_pkg.sv
hw/rtl/smic_if.sv
hw/rtl/smic_front.sv
hw/rtl/smic_back.sv
hw/rtl/soil_moisture_irrigation_ctrl_unit.sv
bench/testbench.sv
